### rtl/drq_pkg.sv
// shared types and constants for the descriptor ring queue
// used by the controller, the datapath and the top level
package drq_pkg;

   localparam int COUNT_W       = 32;
   localparam int RING_SLOTS_W  = 10;
   localparam int ADDR_W        = 64;
   localparam int LENGTH_W      = 32;
   localparam int TAG_W         = 32;
   localparam int DESC_W        = ADDR_W + LENGTH_W + TAG_W;
   localparam int STATUS_W      = 2;

   localparam logic [RING_SLOTS_W-1:0] RING_SLOTS_RESET = 10'd512;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } drq_status_type;

   // which counter the residue unit reduces
   typedef enum logic [1:0] {
      MOD_SEL_WR,
      MOD_SEL_RD,
      MOD_SEL_OCC
   } drq_mod_sel_type;

   typedef struct packed {
      logic            capture;
      logic            execute;
      logic            csr_write;
      logic            mod_start;
      drq_mod_sel_type mod_sel;
   } drq_cmd_type;

   typedef struct packed {
      logic mod_done;
   } drq_stat_type;

endpackage

### rtl/drq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module drq_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/drq_datapath.sv
// ring datapath: counters, slot residues, residue unit, descriptor ram, result fields
// depends on drq_pkg and drq_ram
module drq_datapath #(
   parameter int MAX_SLOTS = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  drq_pkg::drq_cmd_type                cmd,
   output drq_pkg::drq_stat_type               stat,
   input  logic [drq_pkg::RING_SLOTS_W-1:0]    csr_ring_slots,
   input  logic                                req_mode,
   input  logic [drq_pkg::ADDR_W-1:0]          req_buf_addr,
   input  logic [drq_pkg::LENGTH_W-1:0]        req_buf_length,
   input  logic [drq_pkg::TAG_W-1:0]           req_buf_tag,
   output logic [drq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [drq_pkg::ADDR_W-1:0]          rsp_out_addr,
   output logic [drq_pkg::LENGTH_W-1:0]        rsp_out_length,
   output logic [drq_pkg::TAG_W-1:0]           rsp_out_tag,
   output logic [drq_pkg::COUNT_W-1:0]         rsp_occupancy,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full
);

   localparam int SW       = $clog2(MAX_SLOTS + 1);
   localparam int IW       = $clog2(MAX_SLOTS);
   localparam int CW       = drq_pkg::COUNT_W;
   localparam int STEP_W   = $clog2(CW);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CW - 1);
   localparam int DW       = drq_pkg::DESC_W;
   localparam int AW       = drq_pkg::ADDR_W;
   localparam int LW       = drq_pkg::LENGTH_W;
   localparam int TW       = drq_pkg::TAG_W;

   logic [drq_pkg::RING_SLOTS_W-1:0] ring_slots_ff;
   logic                             req_mode_ff;
   logic [AW-1:0]                    req_buf_addr_ff;
   logic [LW-1:0]                    req_buf_length_ff;
   logic [TW-1:0]                    req_buf_tag_ff;
   logic [CW-1:0]                    write_count_ff, write_count_in;
   logic [CW-1:0]                    read_count_ff, read_count_in;
   logic [IW-1:0]                    wr_res_ff, wr_res_in;
   logic [IW-1:0]                    rd_res_ff, rd_res_in;
   logic [IW-1:0]                    occ_res_ff, occ_res_in;
   drq_pkg::drq_status_type          status_ff, status_in;
   logic                             deq_ok_ff;

   logic                             mod_run_ff, mod_run_in;
   logic [STEP_W-1:0]                mod_cnt_ff, mod_cnt_in;
   logic [CW-1:0]                    mod_dividend_ff, mod_dividend_in;
   logic [SW-1:0]                    mod_rem_ff, mod_rem_in;
   drq_pkg::drq_mod_sel_type         mod_sel_ff, mod_sel_in;
   logic                             mod_done_ff, mod_done_in;

   logic [SW-1:0]    size;
   logic [SW-1:0]    size_m1;
   logic             at_full;
   logic             at_empty;
   logic             enq_ok;
   logic             deq_ok;
   logic [SW-1:0]    wr_inc;
   logic [SW-1:0]    rd_inc;
   logic [SW-1:0]    occ_inc;
   logic [SW:0]      mod_trial;
   logic [SW-1:0]    mod_step;
   logic             mod_commit;
   logic [CW-1:0]    mod_operand;
   logic [DW-1:0]    ram_rd_data;

   // effective ring size: zero acts as one, clamp to the slot count
   always_comb begin
      if (ring_slots_ff == '0) begin
         size = SW'(1);
      end else if (32'(ring_slots_ff) > 32'(MAX_SLOTS)) begin
         size = SW'(MAX_SLOTS);
      end else begin
         size = SW'(ring_slots_ff);
      end
   end

   assign size_m1  = size - SW'(1);
   assign at_full  = (SW'(occ_res_ff) == size_m1);
   assign at_empty = (occ_res_ff == '0);
   assign enq_ok   = cmd.execute && (req_mode_ff == drq_pkg::MODE_ENQUEUE) && !at_full;
   assign deq_ok   = cmd.execute && (req_mode_ff == drq_pkg::MODE_DEQUEUE) && !at_empty;

   assign wr_inc  = SW'(wr_res_ff) + SW'(1);
   assign rd_inc  = SW'(rd_res_ff) + SW'(1);
   assign occ_inc = SW'(occ_res_ff) + SW'(1);

   // residue unit: restoring remainder, one dividend bit per cycle
   assign mod_trial  = {mod_rem_ff, mod_dividend_ff[CW-1]};
   assign mod_step   = (mod_trial >= {1'b0, size}) ? SW'(mod_trial - {1'b0, size})
                                                   : SW'(mod_trial);
   assign mod_commit = mod_run_ff && (mod_cnt_ff == STEP_LAST);

   always_comb begin
      case (cmd.mod_sel)
         drq_pkg::MOD_SEL_WR:  mod_operand = write_count_ff;
         drq_pkg::MOD_SEL_RD:  mod_operand = read_count_ff;
         drq_pkg::MOD_SEL_OCC: mod_operand = write_count_ff - read_count_ff;
         default:              mod_operand = write_count_ff;
      endcase
   end

   always_comb begin
      mod_run_in      = mod_run_ff;
      mod_cnt_in      = mod_cnt_ff;
      mod_dividend_in = mod_dividend_ff;
      mod_rem_in      = mod_rem_ff;
      mod_sel_in      = mod_sel_ff;
      mod_done_in     = 1'b0;
      if (cmd.mod_start) begin
         mod_run_in      = 1'b1;
         mod_cnt_in      = '0;
         mod_dividend_in = mod_operand;
         mod_rem_in      = '0;
         mod_sel_in      = cmd.mod_sel;
      end else if (mod_run_ff) begin
         mod_cnt_in      = mod_cnt_ff + STEP_W'(1);
         mod_dividend_in = {mod_dividend_ff[CW-2:0], 1'b0};
         mod_rem_in      = mod_step;
         if (mod_commit) begin
            mod_run_in  = 1'b0;
            mod_done_in = 1'b1;
         end
      end
   end

   always_comb begin
      write_count_in = write_count_ff;
      read_count_in  = read_count_ff;
      wr_res_in      = wr_res_ff;
      rd_res_in      = rd_res_ff;
      occ_res_in     = occ_res_ff;
      status_in      = status_ff;
      if (cmd.execute) begin
         if (req_mode_ff == drq_pkg::MODE_ENQUEUE) begin
            status_in = at_full ? drq_pkg::STATUS_FULL : drq_pkg::STATUS_DONE;
         end else begin
            status_in = at_empty ? drq_pkg::STATUS_EMPTY : drq_pkg::STATUS_DONE;
         end
      end
      if (enq_ok) begin
         write_count_in = write_count_ff + CW'(1);
         wr_res_in      = (wr_inc == size) ? '0 : IW'(wr_inc);
         occ_res_in     = (occ_inc == size) ? '0 : IW'(occ_inc);
      end
      if (deq_ok) begin
         read_count_in = read_count_ff + CW'(1);
         rd_res_in     = (rd_inc == size) ? '0 : IW'(rd_inc);
         occ_res_in    = at_empty ? IW'(size_m1) : occ_res_ff - IW'(1);
      end
      if (mod_commit) begin
         case (mod_sel_ff)
            drq_pkg::MOD_SEL_WR:  wr_res_in  = IW'(mod_step);
            drq_pkg::MOD_SEL_RD:  rd_res_in  = IW'(mod_step);
            drq_pkg::MOD_SEL_OCC: occ_res_in = IW'(mod_step);
            default:              occ_res_in = IW'(mod_step);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_slots_ff  <= drq_pkg::RING_SLOTS_RESET;
         write_count_ff <= '0;
         read_count_ff  <= '0;
         wr_res_ff      <= '0;
         rd_res_ff      <= '0;
         occ_res_ff     <= '0;
         status_ff      <= drq_pkg::STATUS_DONE;
         deq_ok_ff      <= 1'b0;
         mod_run_ff     <= 1'b0;
         mod_cnt_ff     <= '0;
         mod_sel_ff     <= drq_pkg::MOD_SEL_WR;
         mod_done_ff    <= 1'b0;
      end else begin
         if (cmd.csr_write) begin
            ring_slots_ff <= csr_ring_slots;
         end
         write_count_ff <= write_count_in;
         read_count_ff  <= read_count_in;
         wr_res_ff      <= wr_res_in;
         rd_res_ff      <= rd_res_in;
         occ_res_ff     <= occ_res_in;
         status_ff      <= status_in;
         if (cmd.execute) begin
            deq_ok_ff <= deq_ok;
         end
         mod_run_ff  <= mod_run_in;
         mod_cnt_ff  <= mod_cnt_in;
         mod_sel_ff  <= mod_sel_in;
         mod_done_ff <= mod_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_mode_ff       <= req_mode;
         req_buf_addr_ff   <= req_buf_addr;
         req_buf_length_ff <= req_buf_length;
         req_buf_tag_ff    <= req_buf_tag;
      end
      mod_dividend_ff <= mod_dividend_in;
      mod_rem_ff      <= mod_rem_in;
   end

   drq_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (enq_ok),
      .wr_addr (wr_res_ff),
      .wr_data ({req_buf_addr_ff, req_buf_length_ff, req_buf_tag_ff}),
      .rd_en   (deq_ok),
      .rd_addr (rd_res_ff),
      .rd_data (ram_rd_data)
   );

   assign stat.mod_done = mod_done_ff;

   assign rsp_status     = status_ff;
   assign rsp_out_addr   = deq_ok_ff ? ram_rd_data[DW-1 -: AW] : '0;
   assign rsp_out_length = deq_ok_ff ? ram_rd_data[LW+TW-1 -: LW] : '0;
   assign rsp_out_tag    = deq_ok_ff ? ram_rd_data[TW-1:0] : '0;
   assign rsp_occupancy  = write_count_ff - read_count_ff;
   assign rsp_is_empty   = at_empty;
   assign rsp_is_full    = at_full;

   // residues must be reduced against the current size before any item runs
   a_res_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (SW'(wr_res_ff) < size) && (SW'(rd_res_ff) < size)
                      && (SW'(occ_res_ff) < size))
      else $error("slot residue out of range at execute");

   a_no_exec_while_remap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.execute && mod_run_ff))
      else $error("item executed while residues are being recomputed");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      mod_done_ff |-> $past(mod_run_ff))
      else $error("residue done without a run");

endmodule

### rtl/drq_ctrl.sv
// controller for the descriptor ring queue: item sequencing and residue recompute
// depends on drq_pkg
module drq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   output logic                   rsp_strobe,
   output drq_pkg::drq_cmd_type   cmd,
   input  drq_pkg::drq_stat_type  stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_RESP,
      ST_MOD_LOAD,
      ST_MOD_RUN
   } state_type;

   state_type                state_ff, state_in;
   drq_pkg::drq_mod_sel_type sel_ff, sel_in;
   logic                     accept;

   // a pending config write holds off a new item in the same cycle
   assign busy       = ((state_ff == ST_IDLE) && csr_valid) ||
                       ((state_ff != ST_IDLE) && (state_ff != ST_RESP));
   assign csr_ready  = (state_ff == ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = (state_ff == ST_RESP);

   assign cmd.capture   = accept;
   assign cmd.execute   = (state_ff == ST_ISSUE);
   assign cmd.csr_write = csr_valid && csr_ready;
   assign cmd.mod_start = (state_ff == ST_MOD_LOAD);
   assign cmd.mod_sel   = sel_ff;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               state_in = ST_MOD_LOAD;
               sel_in   = drq_pkg::MOD_SEL_WR;
            end else if (accept) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: state_in = ST_RESP;
         ST_RESP: begin
            state_in = accept ? ST_ISSUE : ST_IDLE;
         end
         ST_MOD_LOAD: state_in = ST_MOD_RUN;
         ST_MOD_RUN: begin
            if (stat.mod_done) begin
               case (sel_ff)
                  drq_pkg::MOD_SEL_WR: begin
                     sel_in   = drq_pkg::MOD_SEL_RD;
                     state_in = ST_MOD_LOAD;
                  end
                  drq_pkg::MOD_SEL_RD: begin
                     sel_in   = drq_pkg::MOD_SEL_OCC;
                     state_in = ST_MOD_LOAD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= drq_pkg::MOD_SEL_WR;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   a_done_only_in_run: assert property (@(posedge clock) disable iff (reset)
      stat.mod_done |-> (state_ff == ST_MOD_RUN))
      else $error("residue done outside of recompute");

   a_csr_starts_remap: assert property (@(posedge clock) disable iff (reset)
      cmd.csr_write |=> (state_ff == ST_MOD_LOAD) && (sel_ff == drq_pkg::MOD_SEL_WR))
      else $error("config write did not start a residue recompute");

   a_result_follows_issue: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_strobe)
      else $error("executed item gave no result strobe");

endmodule

### rtl/descriptor_ring_queue_top.sv
// descriptor ring queue top level: controller plus datapath
// depends on drq_pkg, drq_ctrl, drq_datapath, drq_ram
//
//   channel   handshake                ports
//   request   start & !busy            req_mode, req_buf_addr, req_buf_length, req_buf_tag
//   result    rsp_strobe (one cycle)   rsp_status, rsp_out_addr, rsp_out_length, rsp_out_tag,
//                                      rsp_occupancy, rsp_is_empty, rsp_is_full
//   config    csr_valid & csr_ready    csr_ring_slots
//
// an item passes through the issue state, for the single descriptor ram access and
// counter update, then the result state, in which the next item is taken.
// a config write starts a residue recompute of the write, read and occupancy residues
// in turn (one bit a cycle through the shared remainder unit); busy is high throughout.
// reset clears the counters and residues at once; the ram needs no clearing.
// results are never held off: each strobe lasts exactly one cycle.
module descriptor_ring_queue_top #(
   parameter int MAX_SLOTS = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [drq_pkg::ADDR_W-1:0]        req_buf_addr,
   input  logic [drq_pkg::LENGTH_W-1:0]      req_buf_length,
   input  logic [drq_pkg::TAG_W-1:0]         req_buf_tag,
   output logic                              rsp_strobe,
   output logic [drq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [drq_pkg::ADDR_W-1:0]        rsp_out_addr,
   output logic [drq_pkg::LENGTH_W-1:0]      rsp_out_length,
   output logic [drq_pkg::TAG_W-1:0]         rsp_out_tag,
   output logic [drq_pkg::COUNT_W-1:0]       rsp_occupancy,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [drq_pkg::RING_SLOTS_W-1:0]  csr_ring_slots
);

   drq_pkg::drq_cmd_type  cmd;
   drq_pkg::drq_stat_type stat;

   drq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   drq_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_ring_slots (csr_ring_slots),
      .req_mode       (req_mode),
      .req_buf_addr   (req_buf_addr),
      .req_buf_length (req_buf_length),
      .req_buf_tag    (req_buf_tag),
      .rsp_status     (rsp_status),
      .rsp_out_addr   (rsp_out_addr),
      .rsp_out_length (rsp_out_length),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

endmodule
